@@ rtl/lexer_token_classifier_top_defines.svh @@
// ----------------------------------------------------------------------------
// Lexer token classifier assertion macros
// Concurrent assertion shorthands, compiled out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef LEXER_TOKEN_CLASSIFIER_TOP_DEFINES_SVH
`define LEXER_TOKEN_CLASSIFIER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// The condition must never hold while out of reset.
`define LTC_ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error("assertion failed: never");

// The antecedent implies the consequent in the same cycle.
`define LTC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// The antecedent implies the consequent in the next cycle.
`define LTC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define LTC_ASSERT_NEVER(label, cond)
`define LTC_ASSERT_IMPL(label, ante, cons)
`define LTC_ASSERT_NEXT(label, ante, cons)

`endif

`endif

@@ rtl/ltc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lexer token classifier package
// Token type codes, character constants and operator lookup functions.
// ----------------------------------------------------------------------------
package ltc_pkg;

    typedef logic [7:0] t_char;
    typedef logic [5:0] t_token;
    typedef logic [2:0] t_count;

    localparam t_token T_NUMBER       = 6'd0;
    localparam t_token T_STRING       = 6'd1;
    localparam t_token T_IDENT        = 6'd2;
    localparam t_token T_OPEN         = 6'd3;
    localparam t_token T_CLOSE        = 6'd4;
    localparam t_token T_ADD          = 6'd5;
    localparam t_token T_ADD_ASSIGN   = 6'd6;
    localparam t_token T_INCREMENT    = 6'd7;
    localparam t_token T_SUBTRACT     = 6'd8;
    localparam t_token T_NEGATE       = 6'd9;
    localparam t_token T_SUB_ASSIGN   = 6'd10;
    localparam t_token T_DECREMENT    = 6'd11;
    localparam t_token T_MULTIPLY     = 6'd12;
    localparam t_token T_MUL_ASSIGN   = 6'd13;
    localparam t_token T_DIVIDE       = 6'd14;
    localparam t_token T_DIV_ASSIGN   = 6'd15;
    localparam t_token T_FLOOR_DIV    = 6'd16;
    localparam t_token T_FLOOR_ASSIGN = 6'd17;
    localparam t_token T_MODULO       = 6'd18;
    localparam t_token T_MOD_ASSIGN   = 6'd19;
    localparam t_token T_ASSIGN       = 6'd20;
    localparam t_token T_EQUAL        = 6'd21;
    localparam t_token T_LESS         = 6'd22;
    localparam t_token T_MORE         = 6'd23;
    localparam t_token T_LESS_EQUAL   = 6'd24;
    localparam t_token T_MORE_EQUAL   = 6'd25;
    localparam t_token T_NOT_EQUAL    = 6'd26;
    localparam t_token T_NOT          = 6'd27;
    localparam t_token T_INVALID      = 6'd36;
    localparam t_token T_AMBIGUOUS    = 6'd37;
    localparam t_token T_EOE          = 6'd38;
    localparam t_token T_LAST_CODE    = 6'd39;
    localparam t_token T_NO_MATCH     = 6'd63;

    localparam t_count COUNT_MAX = 3'd4;

    localparam t_char C_NEWLINE = 8'h0A;
    localparam t_char C_BANG    = 8'h21;
    localparam t_char C_QUOTE   = 8'h22;
    localparam t_char C_PERCENT = 8'h25;
    localparam t_char C_LPAREN  = 8'h28;
    localparam t_char C_RPAREN  = 8'h29;
    localparam t_char C_STAR    = 8'h2A;
    localparam t_char C_PLUS    = 8'h2B;
    localparam t_char C_MINUS   = 8'h2D;
    localparam t_char C_SLASH   = 8'h2F;
    localparam t_char C_ZERO    = 8'h30;
    localparam t_char C_NINE    = 8'h39;
    localparam t_char C_LESS    = 8'h3C;
    localparam t_char C_EQUALS  = 8'h3D;
    localparam t_char C_GREATER = 8'h3E;
    localparam t_char C_UPPER_A = 8'h41;
    localparam t_char C_UPPER_Z = 8'h5A;
    localparam t_char C_UNDER   = 8'h5F;
    localparam t_char C_LOWER_A = 8'h61;
    localparam t_char C_LOWER_Z = 8'h7A;

    function automatic logic is_digit(input t_char c);
        return (c >= C_ZERO) && (c <= C_NINE);
    endfunction

    function automatic logic is_alpha(input t_char c);
        return ((c >= C_LOWER_A) && (c <= C_LOWER_Z)) ||
               ((c >= C_UPPER_A) && (c <= C_UPPER_Z));
    endfunction

    function automatic t_token op_single(input t_char a);
        t_token t;
        case (a)
            C_LPAREN:  t = T_OPEN;
            C_RPAREN:  t = T_CLOSE;
            C_PLUS:    t = T_ADD;
            C_STAR:    t = T_MULTIPLY;
            C_SLASH:   t = T_DIVIDE;
            C_PERCENT: t = T_MODULO;
            C_EQUALS:  t = T_ASSIGN;
            C_LESS:    t = T_LESS;
            C_GREATER: t = T_MORE;
            C_BANG:    t = T_NOT;
            C_NEWLINE: t = T_EOE;
            default:   t = T_NO_MATCH;
        endcase
        return t;
    endfunction

    function automatic t_token op_double(input t_char a, input t_char b);
        t_token t;
        t = T_NO_MATCH;
        if (b == C_EQUALS) begin
            case (a)
                C_PLUS:    t = T_ADD_ASSIGN;
                C_MINUS:   t = T_SUB_ASSIGN;
                C_STAR:    t = T_MUL_ASSIGN;
                C_SLASH:   t = T_DIV_ASSIGN;
                C_PERCENT: t = T_MOD_ASSIGN;
                C_EQUALS:  t = T_EQUAL;
                C_LESS:    t = T_LESS_EQUAL;
                C_GREATER: t = T_MORE_EQUAL;
                C_BANG:    t = T_NOT_EQUAL;
                default:   t = T_NO_MATCH;
            endcase
        end else if ((a == C_PLUS) && (b == C_PLUS)) begin
            t = T_INCREMENT;
        end else if ((a == C_MINUS) && (b == C_MINUS)) begin
            t = T_DECREMENT;
        end else if ((a == C_SLASH) && (b == C_SLASH)) begin
            t = T_FLOOR_DIV;
        end
        return t;
    endfunction

    function automatic t_token minus_context(input t_token prev);
        t_token t;
        case (prev)
            T_NUMBER, T_STRING, T_IDENT, T_CLOSE, T_INCREMENT, T_DECREMENT:
                t = T_SUBTRACT;
            T_INVALID, T_AMBIGUOUS:
                t = T_AMBIGUOUS;
            default:
                t = (prev <= T_LAST_CODE) ? T_NEGATE : T_AMBIGUOUS;
        endcase
        return t;
    endfunction

endpackage

@@ rtl/lexer_token_classifier_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lexer token classifier
// Classifies one delimited token from its characters, one per request.
// ----------------------------------------------------------------------------
// The block takes characters while o_s_tready is high and keeps running
// flags plus the first three characters of the current token in registers.
// A character marked last produces one registered token type request; other
// characters produce none. Classification is a single pass of shallow logic
// between the token state registers and the result register, sustaining one
// character per clock while results are taken. A skid entry behind the result
// register lets input continue for one more token while a result is stalled.
`include "lexer_token_classifier_top_defines.svh"

module lexer_token_classifier_top
    import ltc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [7:0] char_code, [13:8] prev_type, [15:14] zero
    input  logic        i_s_tlast,   // last
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata    // [5:0] token_type, [7:6] zero
);

    t_char  c;
    t_token prev;
    logic   quote;
    logic   s_accept;
    logic   res_valid;
    logic   out_free;
    t_token res_type;

    t_count r_count;
    t_char  r_fc [0:2];
    logic   r_all_digits;
    logic   r_ident_ok;
    logic   r_starts_quote;
    logic   r_inner_quote;
    logic   r_prior_quote;

    t_count n_count;
    t_char  n_fc [0:2];
    logic   n_all_digits;
    logic   n_ident_ok;
    logic   n_starts_quote;
    logic   n_inner_quote;

    logic   r_out_valid;
    logic   r_skid_valid;
    t_token r_out_type;
    t_token r_skid_type;

    assign c        = i_s_tdata[7:0];
    assign prev     = i_s_tdata[13:8];
    assign quote    = (c == C_QUOTE);
    assign s_accept = i_s_tvalid && o_s_tready;
    assign res_valid = s_accept && i_s_tlast;
    assign out_free = !r_out_valid || i_m_tready;

    assign o_s_tready = !r_skid_valid;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, r_out_type};

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_fc[i] = (r_count == 3'(i)) ? c : r_fc[i];
        end
        if (r_count == 3'd0) begin
            n_ident_ok     = is_alpha(c) || (c == C_UNDER);
            n_all_digits   = is_digit(c);
            n_starts_quote = quote;
            n_inner_quote  = r_inner_quote;
        end else begin
            n_ident_ok     = r_ident_ok && (is_alpha(c) || is_digit(c) || (c == C_UNDER));
            n_all_digits   = r_all_digits && is_digit(c);
            n_starts_quote = r_starts_quote;
            n_inner_quote  = r_inner_quote || ((r_count >= 3'd2) && r_prior_quote);
        end
        n_count = (r_count < COUNT_MAX) ? r_count + 3'd1 : r_count;
    end

    always_comb begin
        res_type = T_NO_MATCH;
        if (n_count == 3'd1) begin
            res_type = op_single(n_fc[0]);
        end else if (n_count == 3'd2) begin
            res_type = op_double(n_fc[0], n_fc[1]);
        end else if ((n_count == 3'd3) && (n_fc[0] == C_SLASH) && (n_fc[1] == C_SLASH) &&
                     (n_fc[2] == C_EQUALS)) begin
            res_type = T_FLOOR_ASSIGN;
        end
        if (res_type == T_NO_MATCH) begin
            if ((n_count == 3'd1) && (n_fc[0] == C_MINUS)) begin
                res_type = minus_context(prev);
            end else if (n_all_digits) begin
                res_type = T_NUMBER;
            end else if (n_starts_quote && quote && (n_count >= 3'd2) && !n_inner_quote) begin
                res_type = T_STRING;
            end else if (n_ident_ok) begin
                res_type = T_IDENT;
            end else begin
                res_type = T_INVALID;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count        <= 3'd0;
            r_fc[0]        <= '0;
            r_fc[1]        <= '0;
            r_fc[2]        <= '0;
            r_all_digits   <= 1'b1;
            r_ident_ok     <= 1'b1;
            r_starts_quote <= 1'b0;
            r_inner_quote  <= 1'b0;
            r_prior_quote  <= 1'b0;
        end else if (s_accept) begin
            if (i_s_tlast) begin
                r_count        <= 3'd0;
                r_fc[0]        <= '0;
                r_fc[1]        <= '0;
                r_fc[2]        <= '0;
                r_all_digits   <= 1'b1;
                r_ident_ok     <= 1'b1;
                r_starts_quote <= 1'b0;
                r_inner_quote  <= 1'b0;
                r_prior_quote  <= 1'b0;
            end else begin
                r_count        <= n_count;
                r_fc[0]        <= n_fc[0];
                r_fc[1]        <= n_fc[1];
                r_fc[2]        <= n_fc[2];
                r_all_digits   <= n_all_digits;
                r_ident_ok     <= n_ident_ok;
                r_starts_quote <= n_starts_quote;
                r_inner_quote  <= n_inner_quote;
                r_prior_quote  <= quote;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= res_valid;
            end
        end else if (res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out_type <= r_skid_valid ? r_skid_type : res_type;
        end else if (res_valid) begin
            r_skid_type <= res_type;
        end
    end

    `LTC_ASSERT_IMPL(a_skid_behind_out, r_skid_valid, r_out_valid)
    `LTC_ASSERT_NEXT(a_last_gives_result, s_accept && i_s_tlast, o_m_tvalid)
    `LTC_ASSERT_IMPL(a_type_in_range, o_m_tvalid, o_m_tdata[5:0] <= T_LAST_CODE)
    `LTC_ASSERT_NEVER(a_count_saturates, r_count > COUNT_MAX)

endmodule

@@ tb/sv/ltc_token_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lexer token classifier checker
// Watches the character and token type streams, predicts each token type
// from the accepted characters and compares it with the block's output.
// ----------------------------------------------------------------------------
module ltc_token_checker
    import ltc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [15:0] i_s_tdata,   // [7:0] char_code, [13:8] prev_type, [15:14] zero
    input  logic        i_s_tlast,   // last
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [7:0]  i_m_tdata,   // [5:0] token_type, [7:6] zero
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);

    t_count seen         = '0;
    t_char  head [3]     = '{default: '0};
    logic   digits_only  = 1'b1;
    logic   ident_valid  = 1'b1;
    logic   opens_quote  = 1'b0;
    logic   inner_quote  = 1'b0;
    logic   prev_quote   = 1'b0;
    t_token expected_types [$];
    t_token oldest;
    int     mismatch_count = 0;
    int     pending_count  = 0;
    int     checked_count  = 0;

    assign o_fail_count = mismatch_count;
    assign o_pending    = pending_count;
    assign o_checked    = checked_count;

    function automatic logic is_letter(input t_char c);
        return (c >= C_UPPER_A && c <= C_UPPER_Z) || (c >= C_LOWER_A && c <= C_LOWER_Z);
    endfunction

    function automatic logic is_numeral(input t_char c);
        return c >= C_ZERO && c <= C_NINE;
    endfunction

    function automatic t_token operator_code(input t_count n, input t_char a,
                                             input t_char b, input t_char c);
        if (n == 3'd3) begin
            return ({a, b, c} == {C_SLASH, C_SLASH, C_EQUALS}) ? T_FLOOR_ASSIGN : T_NO_MATCH;
        end
        if (n == 3'd2) begin
            case ({a, b})
                {C_PLUS, C_EQUALS}:    return T_ADD_ASSIGN;
                {C_MINUS, C_EQUALS}:   return T_SUB_ASSIGN;
                {C_STAR, C_EQUALS}:    return T_MUL_ASSIGN;
                {C_SLASH, C_EQUALS}:   return T_DIV_ASSIGN;
                {C_PERCENT, C_EQUALS}: return T_MOD_ASSIGN;
                {C_EQUALS, C_EQUALS}:  return T_EQUAL;
                {C_LESS, C_EQUALS}:    return T_LESS_EQUAL;
                {C_GREATER, C_EQUALS}: return T_MORE_EQUAL;
                {C_BANG, C_EQUALS}:    return T_NOT_EQUAL;
                {C_PLUS, C_PLUS}:      return T_INCREMENT;
                {C_MINUS, C_MINUS}:    return T_DECREMENT;
                {C_SLASH, C_SLASH}:    return T_FLOOR_DIV;
                default:               return T_NO_MATCH;
            endcase
        end
        if (n == 3'd1) begin
            case (a)
                C_LPAREN:  return T_OPEN;
                C_RPAREN:  return T_CLOSE;
                C_PLUS:    return T_ADD;
                C_STAR:    return T_MULTIPLY;
                C_SLASH:   return T_DIVIDE;
                C_PERCENT: return T_MODULO;
                C_EQUALS:  return T_ASSIGN;
                C_LESS:    return T_LESS;
                C_GREATER: return T_MORE;
                C_BANG:    return T_NOT;
                C_NEWLINE: return T_EOE;
                default:   return T_NO_MATCH;
            endcase
        end
        return T_NO_MATCH;
    endfunction

    function automatic t_token minus_code(input t_token prev);
        if (prev > T_LAST_CODE || prev == T_INVALID || prev == T_AMBIGUOUS) begin
            return T_AMBIGUOUS;
        end
        case (prev)
            T_NUMBER, T_STRING, T_IDENT, T_CLOSE, T_INCREMENT, T_DECREMENT: return T_SUBTRACT;
            default: return T_NEGATE;
        endcase
    endfunction

    function automatic t_token token_code_for(input t_token prev, input logic ends_quote);
        t_token code;
        code = operator_code(seen, head[0], head[1], head[2]);
        if (code != T_NO_MATCH) begin
            return code;
        end
        if (seen == 3'd1 && head[0] == C_MINUS) begin
            return minus_code(prev);
        end
        if (digits_only) begin
            return T_NUMBER;
        end
        if (opens_quote && ends_quote && seen >= 3'd2 && !inner_quote) begin
            return T_STRING;
        end
        return ident_valid ? T_IDENT : T_INVALID;
    endfunction

    task automatic clear_token_state();
        seen        = '0;
        head        = '{default: '0};
        digits_only = 1'b1;
        ident_valid = 1'b1;
        opens_quote = 1'b0;
        inner_quote = 1'b0;
        prev_quote  = 1'b0;
    endtask

    task automatic absorb_char(input t_char c, input logic last_char, input t_token prev);
        logic is_quote;
        is_quote = (c == C_QUOTE);
        if (seen < 3'd3) begin
            head[seen[1:0]] = c;
        end
        if (seen == '0) begin
            ident_valid = is_letter(c) || c == C_UNDER;
            digits_only = is_numeral(c);
            opens_quote = is_quote;
        end else begin
            ident_valid = ident_valid && (is_letter(c) || is_numeral(c) || c == C_UNDER);
            digits_only = digits_only && is_numeral(c);
            if (seen >= 3'd2 && prev_quote) begin
                inner_quote = 1'b1;
            end
        end
        prev_quote = is_quote;
        if (seen < COUNT_MAX) begin
            seen = seen + 3'd1;
        end
        if (last_char) begin
            expected_types.push_back(token_code_for(prev, is_quote));
            clear_token_state();
        end
    endtask

    // Inputs change only at rising edges, so the values seen at the falling
    // edge are the ones that the next rising edge will act on.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            clear_token_state();
            expected_types.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                absorb_char(i_s_tdata[7:0], i_s_tlast, i_s_tdata[13:8]);
            end
            if (i_m_tvalid && i_m_tready) begin
                if (expected_types.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected token type request: expected none, actual %0d",
                             $time, i_m_tdata);
                end else begin
                    oldest = expected_types.pop_front();
                    checked_count++;
                    if (i_m_tdata !== {2'b00, oldest}) begin
                        mismatch_count++;
                        $display("%0t: token type mismatch: expected %0d, actual %0d",
                                 $time, oldest, i_m_tdata);
                    end
                end
            end
        end
        pending_count = expected_types.size();
    end

endmodule

@@ tb/sv/tb_lexer_token_classifier_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lexer token classifier testbench
// Streams directed and random tokens into the classifier one character per
// request under three idling mixes, with a checker predicting every type.
// ----------------------------------------------------------------------------
module tb_lexer_token_classifier_top;
    import ltc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_LIMIT = 2000;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [15:0] i_s_tdata  = '0;
    logic        i_s_tlast  = 1'b0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [7:0]  o_m_tdata;

    int     fail_count;
    int     pending;
    int     checked;
    int     tx_gap_pct   = 34;
    int     rx_stall_pct = 67;
    int     chars_sent   = 0;
    int     tokens_sent  = 0;
    int     cycle_count  = 0;
    t_char  word [$];

    lexer_token_classifier_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    ltc_token_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tlast    (i_s_tlast),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: run stopped at the cycle limit with %0d results outstanding",
                     $time, pending);
            $display("lexer_token_classifier_top regression: fail");
            $finish;
        end
    end

    function automatic string operator_text(input int idx);
        case (idx)
            0:       return "(";
            1:       return ")";
            2:       return "+";
            3:       return "*";
            4:       return "/";
            5:       return "%";
            6:       return "=";
            7:       return "<";
            8:       return ">";
            9:       return "!";
            10:      return "\n";
            11:      return "+=";
            12:      return "-=";
            13:      return "*=";
            14:      return "/=";
            15:      return "%=";
            16:      return "==";
            17:      return "<=";
            18:      return ">=";
            19:      return "!=";
            20:      return "++";
            21:      return "--";
            22:      return "//";
            default: return "//=";
        endcase
    endfunction

    function automatic t_token minus_neighbor();
        case ($urandom_range(0, 9))
            0:       return T_NUMBER;
            1:       return T_STRING;
            2:       return T_IDENT;
            3:       return T_CLOSE;
            4:       return T_INCREMENT;
            5:       return T_DECREMENT;
            6:       return T_INVALID;
            7:       return T_AMBIGUOUS;
            8:       return T_LAST_CODE;
            default: return T_OPEN;
        endcase
    endfunction

    function automatic t_char ident_char();
        case ($urandom_range(0, 3))
            0:       return t_char'($urandom_range(C_UPPER_A, C_UPPER_Z));
            1:       return t_char'($urandom_range(C_LOWER_A, C_LOWER_Z));
            2:       return t_char'($urandom_range(C_ZERO, C_NINE));
            default: return C_UNDER;
        endcase
    endfunction

    function automatic t_char operator_char();
        case ($urandom_range(0, 12))
            0:       return C_PLUS;
            1:       return C_MINUS;
            2:       return C_STAR;
            3:       return C_SLASH;
            4:       return C_PERCENT;
            5:       return C_EQUALS;
            6:       return C_LESS;
            7:       return C_GREATER;
            8:       return C_BANG;
            9:       return C_LPAREN;
            10:      return C_RPAREN;
            11:      return C_NEWLINE;
            default: return C_QUOTE;
        endcase
    endfunction

    task automatic put_text(input string s);
        word.delete();
        for (int k = 0; k < s.len(); k++) begin
            word.push_back(t_char'(s[k]));
        end
    endtask

    task automatic send_char(input t_char c, input logic last_char, input t_token prev);
        logic ready_seen;
        while ($urandom_range(0, 99) < tx_gap_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {2'b00, prev, c};
        i_s_tlast  <= last_char;
        forever begin
            @(negedge i_clk);
            ready_seen = o_s_tready;
            @(posedge i_clk);
            if (ready_seen) begin
                break;
            end
        end
        chars_sent++;
    endtask

    task automatic send_word(input t_token prev);
        for (int k = 0; k < word.size(); k++) begin
            if (k == word.size() - 1) begin
                send_char(word[k], 1'b1, prev);
            end else begin
                send_char(word[k], 1'b0, t_token'($urandom_range(0, 63)));
            end
        end
        tokens_sent++;
    endtask

    task automatic make_random_word(output t_token prev);
        int pick;
        int len;
        pick = $urandom_range(0, 99);
        prev = t_token'($urandom_range(0, 63));
        word.delete();
        if (pick < 25) begin
            put_text(operator_text($urandom_range(0, 23)));
        end else if (pick < 35) begin
            word.push_back(C_MINUS);
            if ($urandom_range(0, 1) == 0) begin
                prev = minus_neighbor();
            end
        end else if (pick < 50) begin
            len = $urandom_range(1, 6);
            for (int k = 0; k < len; k++) begin
                word.push_back(t_char'($urandom_range(C_ZERO, C_NINE)));
            end
            if ($urandom_range(0, 4) == 0) begin
                word[$urandom_range(0, len - 1)] = t_char'($urandom_range(0, 255));
            end
        end else if (pick < 65) begin
            len = $urandom_range(0, 5);
            word.push_back(C_QUOTE);
            for (int k = 0; k < len; k++) begin
                word.push_back(t_char'($urandom_range(8'h20, 8'h7E)));
            end
            if (len > 0 && $urandom_range(0, 6) == 0) begin
                word[$urandom_range(1, len)] = C_QUOTE;
            end
            word.push_back(($urandom_range(0, 6) == 0) ? t_char'($urandom_range(0, 255))
                                                        : C_QUOTE);
        end else if (pick < 85) begin
            len = $urandom_range(0, 7);
            word.push_back(($urandom_range(0, 4) == 0) ? C_UNDER
                           : t_char'($urandom_range(C_LOWER_A, C_LOWER_Z)));
            for (int k = 0; k < len; k++) begin
                word.push_back(ident_char());
            end
            if ($urandom_range(0, 6) == 0) begin
                word[$urandom_range(0, len)] = t_char'($urandom_range(0, 255));
            end
        end else if (pick < 93) begin
            len = $urandom_range(1, 4);
            for (int k = 0; k < len; k++) begin
                word.push_back(operator_char());
            end
        end else begin
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
            for (int k = 0; k < len; k++) begin
                word.push_back(t_char'($urandom_range(0, 255)));
            end
        end
    endtask

    initial begin
        t_token prev;
        int     drain;
        logic   leftover;
        leftover = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        put_text("(");         send_word(T_NUMBER);
        put_text("\n");        send_word(T_LAST_CODE);
        put_text("+=");        send_word(T_IDENT);
        put_text("//=");       send_word(T_IDENT);
        put_text("-");         send_word(T_CLOSE);
        put_text("-");         send_word(T_AMBIGUOUS);
        put_text("-");         send_word(T_ASSIGN);
        put_text("-");         send_word(t_token'(6'h3F));
        put_text("0189");      send_word(T_NUMBER);
        put_text("\"\"");      send_word(T_NUMBER);
        put_text("\"a\"b\"");  send_word(T_NUMBER);
        put_text("\"");        send_word(T_NUMBER);
        put_text("AZaz09_");   send_word(T_NUMBER);
        put_text("@[`{");      send_word(T_NUMBER);
        word.delete();
        word.push_back(8'hFF);
        word.push_back(8'h00);
        word.push_back(8'h80);
        send_word(T_NUMBER);

        while (chars_sent < 1540) begin
            if (chars_sent >= 1040) begin
                tx_gap_pct   = 0;
                rx_stall_pct = 0;
            end else if (chars_sent >= 540) begin
                tx_gap_pct   = 67;
                rx_stall_pct = 34;
            end
            make_random_word(prev);
            send_word(prev);
        end
        i_s_tvalid <= 1'b0;

        drain = 0;
        while (pending != 0 && drain < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (10) @(posedge i_clk);
        if (pending != 0) begin
            leftover = 1'b1;
            $display("%0t: %0d expected token types never arrived", $time, pending);
        end

        $display("Sent %0d characters in %0d tokens; %0d token types were compared.",
                 chars_sent, tokens_sent, checked);
        $display("Covered operators, lone minus contexts, numbers, strings, identifiers and "
                 , "raw bytes under three idling mixes.");
        if (fail_count == 0 && !leftover) begin
            $display("lexer_token_classifier_top regression: pass");
        end else begin
            $display("lexer_token_classifier_top regression: fail");
        end
        $finish;
    end

endmodule

@@ lexer_token_classifier_top.f @@
+incdir+rtl
rtl/ltc_pkg.sv
rtl/lexer_token_classifier_top.sv
tb/sv/ltc_token_checker.sv
tb/sv/tb_lexer_token_classifier_top.sv
